@@ rtl/positional_list_engine_top_assert.svh @@
// Assertion macros shared by the list engine modules.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("list engine check failed");
`define PLE_ASSERT_NEXT(name, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("list engine sequence check failed");
`else
`define PLE_ASSERT(name, prop)
`define PLE_ASSERT_NEXT(name, trig, prop)
`endif

`endif

@@ rtl/ple_pkg.sv @@
package ple_pkg;

  localparam int DEPTH   = 64;
  localparam int ENTRY_W = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CFG_W   = 7;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;

  localparam logic [CFG_W-1:0] LIMIT_RST = CFG_W'(64);

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_APPEND    = 3'd1,
    ACT_REMOVE    = 3'd2,
    ACT_REM_LAST  = 3'd3,
    ACT_READ      = 3'd4,
    ACT_READ_LAST = 3'd5,
    ACT_CLEAR     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PLACE,
    OP_TAKE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    action_t          action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_t          status;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } out_word_t;

  typedef struct packed {
    logic load_req;
    logic eval;
    logic rd_up;
    logic wr_up;
    logic place;
    logic rd_dn;
    logic wr_dn;
    logic take_done;
    logic rd_at;
    logic clr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic up_done;
    logic dn_done;
  } dp_sts_t;

endpackage

@@ rtl/positional_list_engine_top.sv @@
// Ordered list engine: a store of DEPTH entries with insert, append,
// remove, remove-last, read, read-last and clear requests.
// Input channel: in_valid / in_stall / in_word; a word is taken when valid
// is high and stall low. Each request yields exactly one output word on
// out_valid / out_stall / out_word with data, status and entry count.
// cfg_we / cfg_wdata set the capacity limit (reset 64); write while idle.
// Clear, unused actions and refused requests go straight to S_FIN; append
// and read make one store access; insert and remove first shift the
// entries between the position and the end of the list by one place.
// Each entry move is one read and one write of the store, done in
// S_UP_RD/S_UP_WR or S_DN_RD/S_DN_WR. The output word is loaded in S_FIN
// and held in a register, so the next request is accepted while it
// waits. While the receiver stalls a held word, a finished request
// waits and no new one is taken.
// Reset (synchronous, rst_n low) empties the list, drops any pending
// output word and restores the limit; stored entries are not cleared.
module positional_list_engine_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ple_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ple_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic [ple_pkg::CFG_W-1:0] cfg_wdata
);

  ple_pkg::dp_cmd_t cmd;
  ple_pkg::dp_sts_t sts;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ple_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_word)
  );

endmodule

@@ rtl/ple_datapath.sv @@
module ple_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ple_pkg::dp_cmd_t              cmd,
  output ple_pkg::dp_sts_t              sts,
  input  ple_pkg::in_word_t             in_word,
  input  logic                          cfg_we,
  input  logic [ple_pkg::CFG_W-1:0]     cfg_wdata,
  output ple_pkg::out_word_t            out_word
);

  logic [ple_pkg::ENTRY_W-1:0] mem [ple_pkg::DEPTH];

  ple_pkg::in_word_t           req_r;
  ple_pkg::status_t            status_r;
  ple_pkg::status_t            status_nxt;
  ple_pkg::op_t                op_nxt;
  ple_pkg::out_word_t          out_word_r;
  logic [ple_pkg::CNT_W-1:0]   count_r;
  logic [ple_pkg::CNT_W-1:0]   tgt_r;
  logic [ple_pkg::CNT_W-1:0]   tgt_nxt;
  logic [ple_pkg::CNT_W-1:0]   ptr_r;
  logic [ple_pkg::CFG_W-1:0]   limit_r;
  logic [ple_pkg::CNT_W-1:0]   lim;
  logic [ple_pkg::CNT_W-1:0]   pos;
  logic [ple_pkg::CNT_W-1:0]   last;
  logic [ple_pkg::ENTRY_W-1:0] rdata_r;
  logic                        rd_flag_r;
  logic                        full;
  logic                        mem_we;
  logic                        mem_re;
  logic [ple_pkg::ADDR_W-1:0]  waddr;
  logic [ple_pkg::ADDR_W-1:0]  raddr;
  logic [ple_pkg::ENTRY_W-1:0] wdata;
  logic [ple_pkg::CNT_W:0]     ptr_inc;

  assign lim  = (ple_pkg::CNT_W'(limit_r) > ple_pkg::CNT_W'(ple_pkg::DEPTH)) ?
                ple_pkg::CNT_W'(ple_pkg::DEPTH) : ple_pkg::CNT_W'(limit_r);
  assign full = (count_r >= lim);
  assign pos  = ple_pkg::CNT_W'(req_r.position);
  assign last = count_r - 1'b1;

  always_comb begin
    status_nxt = ple_pkg::ST_OK;
    op_nxt     = ple_pkg::OP_NONE;
    tgt_nxt    = pos;
    unique case (req_r.action)
      ple_pkg::ACT_INSERT: begin
        if (pos > count_r) begin
          status_nxt = ple_pkg::ST_RANGE;
        end else if (full) begin
          status_nxt = ple_pkg::ST_FULL;
        end else begin
          op_nxt = ple_pkg::OP_PLACE;
        end
      end
      ple_pkg::ACT_APPEND: begin
        tgt_nxt = count_r;
        if (full) begin
          status_nxt = ple_pkg::ST_FULL;
        end else begin
          op_nxt = ple_pkg::OP_PLACE;
        end
      end
      ple_pkg::ACT_REMOVE: begin
        if (pos >= count_r) begin
          status_nxt = ple_pkg::ST_RANGE;
        end else begin
          op_nxt = ple_pkg::OP_TAKE;
        end
      end
      ple_pkg::ACT_REM_LAST: begin
        tgt_nxt = last;
        if (count_r == '0) begin
          status_nxt = ple_pkg::ST_EMPTY;
        end else begin
          op_nxt = ple_pkg::OP_TAKE;
        end
      end
      ple_pkg::ACT_READ: begin
        if (pos >= count_r) begin
          status_nxt = ple_pkg::ST_RANGE;
        end else begin
          op_nxt = ple_pkg::OP_READ;
        end
      end
      ple_pkg::ACT_READ_LAST: begin
        tgt_nxt = last;
        if (count_r == '0) begin
          status_nxt = ple_pkg::ST_EMPTY;
        end else begin
          op_nxt = ple_pkg::OP_READ;
        end
      end
      ple_pkg::ACT_CLEAR: begin
        op_nxt = ple_pkg::OP_CLEAR;
      end
      default: begin
        op_nxt = ple_pkg::OP_NONE;
      end
    endcase
  end

  assign ptr_inc     = {1'b0, ptr_r} + 1'b1;
  assign sts.op      = op_nxt;
  assign sts.up_done = (ptr_r == tgt_r);
  assign sts.dn_done = (ptr_inc >= {1'b0, count_r});

  assign mem_we = cmd.wr_up | cmd.wr_dn | cmd.place;
  assign mem_re = cmd.rd_up | cmd.rd_dn | cmd.rd_at;
  assign waddr  = cmd.place ? tgt_r[ple_pkg::ADDR_W-1:0] : ptr_r[ple_pkg::ADDR_W-1:0];
  assign wdata  = cmd.place ? req_r.entry_value[ple_pkg::ENTRY_W-1:0] : rdata_r;

  always_comb begin
    priority if (cmd.rd_up) begin
      raddr = ple_pkg::ADDR_W'(ptr_r - 1'b1);
    end else if (cmd.rd_dn) begin
      raddr = ptr_inc[ple_pkg::ADDR_W-1:0];
    end else begin
      raddr = tgt_r[ple_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= ple_pkg::LIMIT_RST;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      priority if (cmd.clr) begin
        count_r <= '0;
      end else if (cmd.place) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.take_done) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
    if (cmd.eval) begin
      status_r  <= status_nxt;
      tgt_r     <= tgt_nxt;
      rd_flag_r <= (op_nxt == ple_pkg::OP_READ);
      ptr_r     <= (op_nxt == ple_pkg::OP_PLACE) ? count_r : tgt_nxt;
    end else if (cmd.wr_up) begin
      ptr_r <= ptr_r - 1'b1;
    end else if (cmd.wr_dn) begin
      ptr_r <= ptr_inc[ple_pkg::CNT_W-1:0];
    end
    if (cmd.load_out) begin
      out_word_r.read_value  <= rd_flag_r ? ple_pkg::VAL_W'(rdata_r) : '0;
      out_word_r.status      <= status_r;
      out_word_r.entry_count <= count_r;
      out_word_r.is_empty    <= (count_r == '0);
    end
  end

  assign out_word = out_word_r;

  `include "positional_list_engine_top_assert.svh"

  `PLE_ASSERT(a_count_bound, count_r <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
  `PLE_ASSERT(a_place_room, cmd.place |-> count_r < lim)
  `PLE_ASSERT(a_shift_up_order, cmd.rd_up |-> ptr_r > tgt_r)
  `PLE_ASSERT_NEXT(a_place_count, cmd.place,
                   count_r == ple_pkg::CNT_W'($past(count_r) + 1'b1))

endmodule

@@ rtl/ple_ctrl.sv @@
module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ple_pkg::dp_sts_t  sts,
  output ple_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_RD,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.eval = 1'b1;
        unique case (sts.op)
          ple_pkg::OP_PLACE: state_nxt = S_UP_RD;
          ple_pkg::OP_TAKE:  state_nxt = S_DN_RD;
          ple_pkg::OP_READ:  state_nxt = S_RD;
          ple_pkg::OP_CLEAR: begin
            cmd.clr   = 1'b1;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_UP_RD: begin
        if (sts.up_done) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_up = 1'b1;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_up = 1'b1;
        state_nxt = S_UP_RD;
      end
      S_DN_RD: begin
        if (sts.dn_done) begin
          cmd.take_done = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.rd_dn = 1'b1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_dn = 1'b1;
        state_nxt = S_DN_RD;
      end
      S_RD: begin
        cmd.rd_at = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  `include "positional_list_engine_top_assert.svh"

  `PLE_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC)
  `PLE_ASSERT_NEXT(a_result_shown, cmd.load_out, out_valid_r && state_r == S_IDLE)
  `PLE_ASSERT(a_no_overwrite, (state_r == S_FIN && out_valid_r && out_stall) |-> !cmd.load_out)

endmodule
